@@ rtl/core/fpbc_pkg.sv @@
// Shared constants and controller/datapath command and status types.
package fpbc_pkg;
	localparam int TableEntries = 2048;
	localparam int IdxW = $clog2(TableEntries);
	localparam int OccW = $clog2(TableEntries + 1);
	localparam logic [15:0] MinFrameBytes = 16'd34;

	typedef struct packed {
		logic start;    // load descriptor, reset scan index
		logic advance;  // step scan index
		logic write;    // write current entry (update or insert)
		logic insert;   // write targets the occupancy slot
		logic finish;   // load the result register
		logic rec;      // result is recorded
	} fpbc_cmd_t;

	typedef struct packed {
		logic is_short;
		logic hit;       // key compare of the registered read entry
		logic last;      // read index at last valid entry
		logic empty;     // no valid entries
		logic full;
	} fpbc_sts_t;
endpackage

@@ rtl/core/flow_pair_packet_byte_counter.sv @@
// Top level of the per-flow packet and byte counter table.
// Input channel: in_valid/in_ready with frame_length, src_addr, dst_addr.
// Output channel: out_valid/out_ready with verdict, recorded, packet_count,
// byte_total. One result per accepted descriptor.
// The table is searched linearly over occupied entries, one per cycle
// through a registered memory read, until a hit or the last occupied
// entry; a short frame or an empty table skips the scan. The next
// descriptor is taken in the cycle after the result transfers.
// One item is in work at a time.
// Reset clears the occupancy count and control; memory contents are only
// read below the occupancy, so no clearing pass is needed.
// A stalled result holds in the output register; no new descriptor is
// taken until it transfers.
module flow_pair_packet_byte_counter import fpbc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] frame_length,
	input  logic [31:0] src_addr,
	input  logic [31:0] dst_addr,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        verdict,
	output logic        recorded,
	output logic [63:0] packet_count,
	output logic [63:0] byte_total
);
	fpbc_cmd_t cmd;
	fpbc_sts_t sts;

	fpbc_ctrl u_ctrl (.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.sts, .cmd);
	fpbc_datapath u_dp (.clk, .arst_n, .cmd, .sts, .frame_length, .src_addr,
		.dst_addr, .verdict, .recorded, .packet_count, .byte_total);
endmodule

@@ rtl/core/fpbc_datapath.sv @@
// Flow table memories, linear scan, counter update and result register.
module fpbc_datapath import fpbc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  fpbc_cmd_t   cmd,
	output fpbc_sts_t   sts,
	input  logic [15:0] frame_length,
	input  logic [31:0] src_addr,
	input  logic [31:0] dst_addr,
	output logic        verdict,
	output logic        recorded,
	output logic [63:0] packet_count,
	output logic [63:0] byte_total
);
	logic [63:0] key_mem [TableEntries];
	logic [63:0] pkt_mem [TableEntries];
	logic [63:0] byt_mem [TableEntries];
	logic [63:0] key_q, rd_key_q, rd_pkt_q, rd_byt_q;
	logic [15:0] len_q;
	logic [IdxW-1:0] idx_q, rd_idx_q;
	logic [OccW-1:0] occ_q;
	logic [63:0] new_pkt, new_byt;
	logic [IdxW-1:0] wr_idx;

	assign wr_idx = cmd.insert ? occ_q[IdxW-1:0] : rd_idx_q;
	assign new_pkt = cmd.insert ? 64'd1 : rd_pkt_q + 64'd1;
	assign new_byt = cmd.insert ? {48'd0, len_q} : rd_byt_q + {48'd0, len_q};

	always_ff @(posedge clk) begin
		rd_key_q <= key_mem[idx_q];
		rd_pkt_q <= pkt_mem[idx_q];
		rd_byt_q <= byt_mem[idx_q];
		if (cmd.write) begin
			key_mem[wr_idx] <= key_q;
			pkt_mem[wr_idx] <= new_pkt;
			byt_mem[wr_idx] <= new_byt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			idx_q <= '0;
		end else begin
			if (cmd.start) idx_q <= '0;
			else if (cmd.advance) idx_q <= idx_q + 1'b1;
			if (cmd.write && cmd.insert) occ_q <= occ_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_q <= idx_q;
		if (cmd.start) begin
			key_q <= {src_addr, dst_addr};
			len_q <= frame_length;
		end
		if (cmd.finish) begin
			verdict      <= (len_q < MinFrameBytes);
			recorded     <= cmd.rec;
			packet_count <= cmd.rec ? new_pkt : 64'd0;
			byte_total   <= cmd.rec ? new_byt : 64'd0;
		end
	end

	assign sts.is_short = len_q < MinFrameBytes;
	assign sts.hit      = rd_key_q == key_q;
	assign sts.last     = {1'b0, rd_idx_q} == occ_q - 1'b1;
	assign sts.empty    = occ_q == '0;
	assign sts.full     = occ_q == OccW'(TableEntries);
endmodule

@@ rtl/core/fpbc_ctrl.sv @@
// Controller: accept, scan the table, write back and present the result.
module fpbc_ctrl import fpbc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  fpbc_sts_t sts,
	output fpbc_cmd_t cmd
);
	localparam logic [2:0] S_IDLE = 3'd0, S_CHK = 3'd1, S_RD = 3'd2,
		S_CMP = 3'd3, S_OUT = 3'd4;
	logic [2:0] state_q, state_d;
	logic ov_d;

	assign in_ready = (state_q == S_IDLE) && !out_valid;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		ov_d = out_valid && !out_ready;
		case (state_q)
			S_IDLE: if (in_valid && in_ready) begin
				cmd.start = 1'b1;
				state_d = S_CHK;
			end
			S_CHK: begin
				if (sts.is_short || sts.empty) begin
					state_d = S_OUT;
				end else begin
					cmd.advance = 1'b1;
					state_d = S_CMP;
				end
			end
			S_RD: begin
				cmd.advance = 1'b1;
				state_d = S_CMP;
			end
			S_CMP: begin
				if (sts.hit) begin
					cmd.write = 1'b1; cmd.finish = 1'b1; cmd.rec = 1'b1;
					ov_d = 1'b1; state_d = S_IDLE;
				end else if (sts.last) begin
					state_d = S_OUT;
				end else begin
					cmd.advance = 1'b1;
				end
			end
			S_OUT: begin
				// miss or short frame: insert on a miss if room
				cmd.finish = 1'b1;
				if (!sts.is_short && !sts.full) begin
					cmd.write = 1'b1; cmd.insert = 1'b1; cmd.rec = 1'b1;
				end
				ov_d = 1'b1; state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			out_valid <= ov_d;
		end
	end

`ifndef SYNTH
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == S_IDLE || state_q == S_CHK) else $error("overlap");
	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> state_q == S_IDLE && out_valid) else $error("finish");
	a_insert_only_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |-> state_q == S_OUT) else $error("insert");
`endif
endmodule

@@ tb/flow_pair_packet_byte_counter_test.sv @@
// Testbench for the per-flow packet and byte counter table.
module flow_pair_packet_byte_counter_test import fpbc_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IdleLimit = 20000;

	typedef struct {
		logic        verdict;
		logic        recorded;
		logic [63:0] packet_count;
		logic [63:0] byte_total;
	} flow_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [15:0] frame_length;
	logic [31:0] src_addr;
	logic [31:0] dst_addr;
	logic        out_valid;
	logic        out_ready;
	logic        verdict;
	logic        recorded;
	logic [63:0] packet_count;
	logic [63:0] byte_total;

	flow_pair_packet_byte_counter i_dut (.*);

	// predicted table state
	int          flow_slot[logic [63:0]];
	logic [63:0] flow_packets[TableEntries];
	logic [63:0] flow_bytes[TableEntries];
	int          flows_used;
	logic [63:0] flow_key_list[$];

	flow_result_t expected_results[$];
	int errors;
	int idle_cycles;
	int burst_left;
	bit gaps_on;
	int ready_mode;
	int hold_off;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic flow_result_t count_frame(logic [15:0] len, logic [31:0] src,
			logic [31:0] dst);
		flow_result_t r;
		logic [63:0] key;
		int slot;
		key = {src, dst};
		r = '{1'b0, 1'b0, 64'd0, 64'd0};
		if (len < MinFrameBytes) begin
			r.verdict = 1'b1;
		end else if (flow_slot.exists(key)) begin
			slot = flow_slot[key];
			flow_packets[slot] += 64'd1;
			flow_bytes[slot] += {48'd0, len};
			r.recorded = 1'b1;
			r.packet_count = flow_packets[slot];
			r.byte_total = flow_bytes[slot];
		end else if (flows_used < TableEntries) begin
			flow_slot[key] = flows_used;
			flow_packets[flows_used] = 64'd1;
			flow_bytes[flows_used] = {48'd0, len};
			flow_key_list.push_back(key);
			flows_used++;
			r.recorded = 1'b1;
			r.packet_count = 64'd1;
			r.byte_total = {48'd0, len};
		end
		return r;
	endfunction

	task automatic send_frame(logic [15:0] len, logic [31:0] src, logic [31:0] dst);
		if (gaps_on && burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		if (burst_left > 0) burst_left--;
		in_valid <= 1'b1;
		frame_length <= len;
		src_addr <= src;
		dst_addr <= dst;
		forever begin
			@(negedge clk);
			if (in_ready) break;
		end
		@(posedge clk);
		expected_results.push_back(count_frame(len, src, dst));
	endtask

	function automatic logic [15:0] long_enough_length();
		return logic'($urandom_range(0, 3) == 0) ? 16'($urandom_range(34, 40))
			: 16'($urandom_range(34, 65535));
	endfunction

	// receiver stall pattern plus an optional long hold-off
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off > 0) begin
				out_ready <= 1'b0;
				hold_off--;
			end else begin
				case (ready_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 3) != 0);
					default: out_ready <= ($urandom_range(0, 1) != 0);
				endcase
			end
		end
	end

	// compare each result transfer with the oldest expectation; time out when idle
	always @(negedge clk) begin
		flow_result_t e;
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IdleLimit) begin
				$display("%0t timeout: no transfer for %0d cycles", $time, IdleLimit);
				$display("FAIL flow_pair_packet_byte_counter");
				$finish;
			end
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t unexpected result: verdict %0b recorded %0b", $time,
						verdict, recorded);
					errors++;
				end else begin
					e = expected_results.pop_front();
					if (verdict !== e.verdict) begin
						$display("%0t verdict: expected %0b actual %0b", $time, e.verdict,
							verdict);
						errors++;
					end
					if (recorded !== e.recorded) begin
						$display("%0t recorded: expected %0b actual %0b", $time,
							e.recorded, recorded);
						errors++;
					end
					if (packet_count !== e.packet_count) begin
						$display("%0t packet_count: expected %0h actual %0h", $time,
							e.packet_count, packet_count);
						errors++;
					end
					if (byte_total !== e.byte_total) begin
						$display("%0t byte_total: expected %0h actual %0h", $time,
							e.byte_total, byte_total);
						errors++;
					end
				end
			end
		end
	end

	task automatic test_directed();
		send_frame(16'd0, 32'd0, 32'd0);
		send_frame(16'd33, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_frame(16'd34, 32'd0, 32'd0);
		send_frame(16'd34, 32'd0, 32'd0);
		send_frame(16'd65535, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_frame(16'd65535, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_frame(16'd33, 32'd0, 32'd0);
		send_frame(16'hAAAA, 32'hAAAA_AAAA, 32'h5555_5555);
		send_frame(16'h5555, 32'h5555_5555, 32'hAAAA_AAAA);
		send_frame(16'd1500, 32'hAAAA_AAAA, 32'h5555_5555);
		// swapped pair is a different flow
		send_frame(16'd64, 32'h5555_5555, 32'hAAAA_AAAA);
		send_frame(16'd64, 32'd0, 32'hFFFF_FFFF);
		send_frame(16'd64, 32'hFFFF_FFFF, 32'd0);
		send_frame(16'd35, 32'd0, 32'd0);
	endtask

	task automatic test_random_traffic(int count);
		logic [63:0] pool[48];
		logic [63:0] key;
		int pick;
		foreach (pool[i]) pool[i] = {$urandom(), $urandom()};
		for (int n = 0; n < count; n++) begin
			if (n % 300 == 0) ready_mode = $urandom_range(0, 2);
			pick = $urandom_range(0, 99);
			key = (pick < 80) ? pool[$urandom_range(0, 47)] : {$urandom(), $urandom()};
			if (pick >= 90) send_frame(16'($urandom_range(0, 33)), key[63:32], key[31:0]);
			else send_frame(long_enough_length(), key[63:32], key[31:0]);
		end
	endtask

	task automatic test_output_hold();
		hold_off = 400;
		for (int n = 0; n < 12; n++)
			send_frame(long_enough_length(), $urandom(), 32'($urandom_range(0, 3)));
	endtask

	task automatic test_table_full();
		logic [63:0] key;
		gaps_on = 1'b0;
		ready_mode = 0;
		while (flows_used < TableEntries)
			send_frame(16'($urandom_range(34, 65535)), $urandom(), $urandom());
		gaps_on = 1'b1;
		ready_mode = 1;
		for (int n = 0; n < 40; n++) begin
			case ($urandom_range(0, 2))
				0: send_frame(long_enough_length(), $urandom(), $urandom());
				1: begin
					key = flow_key_list[$urandom_range(0, TableEntries - 1)];
					send_frame(long_enough_length(), key[63:32], key[31:0]);
				end
				default: send_frame(16'($urandom_range(0, 33)), $urandom(), $urandom());
			endcase
		end
	endtask

	initial begin
		in_valid = 1'b0;
		frame_length = '0;
		src_addr = '0;
		dst_addr = '0;
		errors = 0;
		idle_cycles = 0;
		burst_left = 0;
		gaps_on = 1'b1;
		ready_mode = 1;
		hold_off = 0;
		flows_used = 0;
		@(posedge arst_n);
		@(posedge clk);
		test_directed();
		test_random_traffic(1400);
		test_output_hold();
		test_table_full();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (TableEntries + 20) @(posedge clk);
		if (errors == 0) $display("PASS flow_pair_packet_byte_counter");
		else $display("FAIL flow_pair_packet_byte_counter");
		$finish;
	end
endmodule

@@ sim.f @@
rtl/core/fpbc_pkg.sv
rtl/core/fpbc_datapath.sv
rtl/core/fpbc_ctrl.sv
rtl/core/flow_pair_packet_byte_counter.sv
tb/flow_pair_packet_byte_counter_test.sv
